[rtl/core/rmlm_pkg.sv]
// ----------------------------------------------------------------------------
// rmlm_pkg
// Shared types, widths and helper functions for the lowest-metric route
// lookup block.
// ----------------------------------------------------------------------------
package rmlm_pkg;

    localparam int ADDR_W   = 32;
    localparam int METRIC_W = 32;
    localparam int IFACE_W  = 8;
    localparam int PREFIX_W = 6;

    localparam logic [ADDR_W-1:0]   ALL_ONES  = '1;
    localparam logic [PREFIX_W-1:0] FULL_PREFIX = PREFIX_W'(ADDR_W);

    // One route entry as held in the input register
    typedef struct packed {
        logic [ADDR_W-1:0]   target_addr;
        logic [ADDR_W-1:0]   route_dest;
        logic [ADDR_W-1:0]   route_mask;
        logic [METRIC_W-1:0] route_metric;
        logic [IFACE_W-1:0]  route_iface;
        logic                first_entry;
        logic                last_entry;
    } entry_t;

    // Running best route of the current query
    typedef struct packed {
        logic                have_best;
        logic [METRIC_W-1:0] cost;
        logic [ADDR_W-1:0]   netmask;
        logic [PREFIX_W-1:0] prefix;
        logic [IFACE_W-1:0]  port;
    } best_t;

    // One lookup result
    typedef struct packed {
        logic                found;
        logic [IFACE_W-1:0]  best_iface;
        logic [ADDR_W-1:0]   result_mask;
        logic [PREFIX_W-1:0] prefix_len;
        logic [ADDR_W-1:0]   broadcast;
    } result_t;

    // Prefix length of a mask: width minus its trailing zeros, 0 for a zero mask.
    // Isolate the lowest set bit, then encode its position with OR terms.
    function automatic logic [PREFIX_W-1:0] mask_prefix(input logic [ADDR_W-1:0] m);
        logic [ADDR_W-1:0]   low;
        logic [PREFIX_W-2:0] idx;
        low = m & (~m + ADDR_W'(1));
        idx = '0;
        for (int i = 0; i < ADDR_W; i++)
        begin
            if (low[i])
            begin
                idx = idx | (PREFIX_W-1)'(i);
            end
        end
        if (m == '0)
        begin
            return '0;
        end
        return FULL_PREFIX - {1'b0, idx};
    endfunction

    // Mask with p leading ones; p of 32 or more saturates to all ones
    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PREFIX_W-1:0] p);
        if (p == '0)
        begin
            return '0;
        end
        if (p >= FULL_PREFIX)
        begin
            return ALL_ONES;
        end
        return ~(ALL_ONES >> p);
    endfunction

endpackage

[rtl/core/rmlm_if.sv]
// ----------------------------------------------------------------------------
// rmlm_if
// Valid/ready channels of the route lookup block: route entries in,
// lookup results out.
// ----------------------------------------------------------------------------
interface rmlm_entry_if;
    import rmlm_pkg::*;

    logic                valid;
    logic                ready;
    logic [ADDR_W-1:0]   target_addr;
    logic [ADDR_W-1:0]   route_dest;
    logic [ADDR_W-1:0]   route_mask;
    logic [METRIC_W-1:0] route_metric;
    logic [IFACE_W-1:0]  route_iface;
    logic                first_entry;
    logic                last_entry;

    modport source (
        output valid, target_addr, route_dest, route_mask, route_metric,
               route_iface, first_entry, last_entry,
        input  ready
    );

    modport sink (
        input  valid, target_addr, route_dest, route_mask, route_metric,
               route_iface, first_entry, last_entry,
        output ready
    );
endinterface

interface rmlm_result_if;
    import rmlm_pkg::*;

    logic                valid;
    logic                ready;
    logic                found;
    logic [IFACE_W-1:0]  best_iface;
    logic [ADDR_W-1:0]   result_mask;
    logic [PREFIX_W-1:0] prefix_len;
    logic [ADDR_W-1:0]   broadcast;

    modport source (
        output valid, found, best_iface, result_mask, prefix_len, broadcast,
        input  ready
    );

    modport sink (
        input  valid, found, best_iface, result_mask, prefix_len, broadcast,
        output ready
    );
endinterface

[rtl/core/rmlm_select.sv]
// ----------------------------------------------------------------------------
// rmlm_select
// Route match and metric compare; holds the best route of the running query
// and presents its updated value for the entry being consumed.
// ----------------------------------------------------------------------------
module rmlm_select
    import rmlm_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   advance,
    input  entry_t entry,
    output best_t  best_next
);

    best_t best_reg;
    best_t base;
    logic  match;
    logic  better;

    // Start of query clears the running best before this entry is examined
    always_comb
    begin
        if (entry.first_entry)
        begin
            base = '{have_best: 1'b0, cost: ALL_ONES, netmask: '0, prefix: '0, port: '0};
        end
        else
        begin
            base = best_reg;
        end
    end

    // Masked compare and strict metric compare
    assign match  = ((entry.target_addr & entry.route_mask)
                     == (entry.route_dest & entry.route_mask));
    assign better = !base.have_best || (entry.route_metric < base.cost);

    always_comb
    begin
        best_next = base;
        if (match && better)
        begin
            best_next.have_best = 1'b1;
            best_next.cost      = entry.route_metric;
            best_next.netmask   = entry.route_mask;
            best_next.prefix    = mask_prefix(entry.route_mask);
            best_next.port      = entry.route_iface;
        end
    end

    // Best route state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg <= '{have_best: 1'b0, cost: ALL_ONES, netmask: '0, prefix: '0, port: '0};
        end
        else if (advance)
        begin
            best_reg <= best_next;
        end
    end

endmodule

[rtl/core/rmlm_format.sv]
// ----------------------------------------------------------------------------
// rmlm_format
// Builds the lookup result from the chosen route: mask override, prefix
// length and broadcast address; all zero when no route matched.
// ----------------------------------------------------------------------------
module rmlm_format
    import rmlm_pkg::*;
(
    input  best_t               best,
    input  logic [PREFIX_W-1:0] override_prefix,
    input  logic [ADDR_W-1:0]   target_addr,
    output result_t             result
);

    logic [ADDR_W-1:0]   mask;
    logic [PREFIX_W-1:0] prefix;

    // Nonzero override replaces the route mask
    always_comb
    begin
        if (override_prefix == '0)
        begin
            mask   = best.netmask;
            prefix = best.prefix;
        end
        else
        begin
            mask   = prefix_mask(override_prefix);
            prefix = (override_prefix >= FULL_PREFIX) ? FULL_PREFIX : override_prefix;
        end
    end

    always_comb
    begin
        result = '0;
        if (best.have_best)
        begin
            result.found       = 1'b1;
            result.best_iface  = best.port;
            result.result_mask = mask;
            result.prefix_len  = prefix;
            result.broadcast   = target_addr | ~mask;
        end
    end

endmodule

[rtl/core/route_match_lowest_metric.sv]
// ----------------------------------------------------------------------------
// route_match_lowest_metric
// Lowest-metric IPv4 route lookup over a stream of route entries.
// Result: the last entry of a query passes the input register, then the result register, which holds it valid.
// Throughput: one route entry per cycle; input register, one compare/select
// stage and a result register, with the input stalling only when a finished
// result has not been taken and another query end is waiting to complete.
// Reset: clears the running best route, the override prefix and both stages.
// ----------------------------------------------------------------------------
module route_match_lowest_metric
    import rmlm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [PREFIX_W-1:0] cfg_wr_data,
    rmlm_entry_if.sink          entry,
    rmlm_result_if.source       result
);

    logic [PREFIX_W-1:0] override_reg;
    logic                s1_valid_reg;
    entry_t              s1_data_reg;
    logic                res_valid_reg;
    result_t             res_data_reg;
    logic                out_free;
    logic                advance;
    best_t               best_next;
    result_t             res_next;

    // Stage control
    assign out_free    = !res_valid_reg || result.ready;
    assign advance     = s1_valid_reg && (!s1_data_reg.last_entry || out_free);
    assign entry.ready = !s1_valid_reg || advance;

    // Override prefix register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            override_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            override_reg <= cfg_wr_data;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (entry.ready)
        begin
            s1_valid_reg <= entry.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (entry.valid && entry.ready)
        begin
            s1_data_reg <= '{target_addr:  entry.target_addr,
                             route_dest:   entry.route_dest,
                             route_mask:   entry.route_mask,
                             route_metric: entry.route_metric,
                             route_iface:  entry.route_iface,
                             first_entry:  entry.first_entry,
                             last_entry:   entry.last_entry};
        end
    end

    rmlm_select u_select (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .entry     (s1_data_reg),
        .best_next (best_next)
    );

    rmlm_format u_format (
        .best            (best_next),
        .override_prefix (override_reg),
        .target_addr     (s1_data_reg.target_addr),
        .result          (res_next)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance && s1_data_reg.last_entry)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_data_reg.last_entry)
        begin
            res_data_reg <= res_next;
        end
    end

    assign result.valid       = res_valid_reg;
    assign result.found       = res_data_reg.found;
    assign result.best_iface  = res_data_reg.best_iface;
    assign result.result_mask = res_data_reg.result_mask;
    assign result.prefix_len  = res_data_reg.prefix_len;
    assign result.broadcast   = res_data_reg.broadcast;

`ifndef SYNTHESIS
    // A miss reports all-zero fields
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_data_reg.found) |->
        (res_data_reg.best_iface == '0 && res_data_reg.result_mask == '0 &&
         res_data_reg.prefix_len == '0 && res_data_reg.broadcast == '0))
        else $error("miss result carries nonzero fields");

    // Prefix length stays in range and is zero exactly for a zero mask
    a_prefix_mask: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_data_reg.found) |->
        (res_data_reg.prefix_len <= FULL_PREFIX &&
         ((res_data_reg.result_mask == '0) == (res_data_reg.prefix_len == '0))))
        else $error("prefix length inconsistent with mask");

    // A query end waiting on a full result register is held, not dropped
    a_last_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_data_reg.last_entry && !out_free) |=>
        (s1_valid_reg && $stable(s1_data_reg)))
        else $error("stalled query end lost from input register");

    // A pending result is never overwritten while the output stalls
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !result.ready) |-> !advance || !s1_data_reg.last_entry)
        else $error("result register overrun");
`endif

endmodule
